// ===== rtl/nirp_pkg.sv =====
// nirp_pkg: shared types and constants for the nec ir pulse decoder
// word formats of both channels, configuration indexes and pulse windows
// no dependencies
package nirp_pkg;

    // pulse windows in microseconds, bounds excluded
    localparam logic [13:0] BIT0_LO   = 14'd300;
    localparam logic [13:0] BIT0_HI   = 14'd800;
    localparam logic [13:0] BIT1_LO   = 14'd1400;
    localparam logic [13:0] BIT1_HI   = 14'd1800;
    localparam logic [13:0] REPEAT_LO = 14'd2100;
    localparam logic [13:0] REPEAT_HI = 14'd2500;
    localparam logic [13:0] LEADER_LO = 14'd4200;
    localparam logic [13:0] LEADER_HI = 14'd4700;

    // symbol count milestones
    localparam logic [5:0] SYM_ADDR_DONE = 6'd16;
    localparam logic [5:0] SYM_CMD_DONE  = 6'd24;
    localparam logic [5:0] SYM_CHK_DONE  = 6'd32;
    localparam logic [5:0] SYM_FINISHED  = 6'd33;
    localparam logic [5:0] SYM_REPEAT    = 6'd34;
    localparam logic [5:0] SYM_MAX       = 6'd63;

    localparam logic [7:0] CNT8_MAX = 8'hff;

    // configuration reset values
    localparam logic [7:0] RST_REPEAT_SKIP    = 8'd3;
    localparam logic [7:0] RST_FRAME_TIMEOUT  = 8'd3;
    localparam logic [7:0] RST_REPEAT_TIMEOUT = 8'd9;

    // configuration register indexes
    typedef enum logic [1:0] {
        CFG_REPEAT_SKIP    = 2'd0,
        CFG_FRAME_TIMEOUT  = 2'd1,
        CFG_REPEAT_TIMEOUT = 2'd2
    } cfg_index_t;

    localparam int unsigned CFG_INDEX_W = 2;

    typedef struct packed {
        logic        mode;
        logic [13:0] pulse_width;
    } ir_word_t;

    typedef struct packed {
        logic [7:0] key_code;
        logic       is_repeat;
    } key_word_t;

    typedef struct packed {
        logic [7:0] repeat_skip_count;
        logic [7:0] frame_timeout_ticks;
        logic [7:0] repeat_timeout_ticks;
    } cfg_t;

    typedef struct packed {
        logic      valid;
        key_word_t word;
    } result_t;

endpackage

// ===== rtl/nirp_core.sv =====
// nirp_core: decoder state and combinational next-state logic
// one accepted word updates the state and may raise one result
// depends on nirp_pkg
module nirp_core
    import nirp_pkg::*;
(
    input  logic     clk,
    input  logic     rst_n,
    input  logic     fire,
    input  ir_word_t word,
    input  cfg_t     cfg,
    output result_t  result
);

    logic        pair_started_reg, pair_started_next;
    logic        receiving_reg, receiving_next;
    logic [7:0]  idle_ticks_reg, idle_ticks_next;
    logic [15:0] shift_bits_reg, shift_bits_next;
    logic [5:0]  symbol_count_reg, symbol_count_next;
    logic [7:0]  repeat_seen_reg, repeat_seen_next;
    logic [7:0]  held_key_reg, held_key_next;

    // pulse classification
    logic is_bit0, is_bit1, is_rep, is_leader;

    assign is_bit0   = (word.pulse_width > BIT0_LO)   && (word.pulse_width < BIT0_HI);
    assign is_bit1   = (word.pulse_width > BIT1_LO)   && (word.pulse_width < BIT1_HI);
    assign is_rep    = (word.pulse_width > REPEAT_LO) && (word.pulse_width < REPEAT_HI);
    assign is_leader = (word.pulse_width > LEADER_LO) && (word.pulse_width < LEADER_HI);

    // next state and result
    always_comb
    begin
        logic [5:0]  sc;
        logic [15:0] sb;
        logic [7:0]  hk;
        sc = symbol_count_reg;
        sb = shift_bits_reg;
        hk = held_key_reg;
        pair_started_next = pair_started_reg;
        receiving_next    = receiving_reg;
        idle_ticks_next   = idle_ticks_reg;
        shift_bits_next   = shift_bits_reg;
        symbol_count_next = symbol_count_reg;
        repeat_seen_next  = repeat_seen_reg;
        held_key_next     = held_key_reg;
        result            = '0;

        if (fire)
        begin
            if (!word.mode)
            begin
                // timer tick: timeout handling
                if (receiving_reg)
                begin
                    if ((idle_ticks_reg > cfg.frame_timeout_ticks) &&
                        ((repeat_seen_reg == 8'd0) ||
                         (idle_ticks_reg > cfg.repeat_timeout_ticks)))
                    begin
                        receiving_next = 1'b0;
                    end
                    if (idle_ticks_reg != CNT8_MAX)
                    begin
                        idle_ticks_next = idle_ticks_reg + 8'd1;
                    end
                end
            end
            else if (!pair_started_reg)
            begin
                // first edge of a pair
                pair_started_next = 1'b1;
                idle_ticks_next   = 8'd0;
            end
            else
            begin
                pair_started_next = 1'b0;
                // symbol intake
                if (receiving_reg)
                begin
                    priority if (is_bit0 || is_bit1)
                    begin
                        sb = {shift_bits_reg[14:0], is_bit1};
                        if (sc != SYM_MAX)
                        begin
                            sc = sc + 6'd1;
                        end
                    end
                    else if (is_rep)
                    begin
                        if ((repeat_seen_reg > cfg.repeat_skip_count) && (sc != SYM_MAX))
                        begin
                            sc = sc + 6'd1;
                        end
                        if (repeat_seen_reg != CNT8_MAX)
                        begin
                            repeat_seen_next = repeat_seen_reg + 8'd1;
                        end
                    end
                    else
                    begin
                        sc = symbol_count_reg;
                    end
                end
                else if (is_leader)
                begin
                    receiving_next   = 1'b1;
                    sc               = 6'd0;
                    repeat_seen_next = 8'd0;
                end

                // frame milestones
                case (sc)
                    SYM_ADDR_DONE:
                    begin
                        if (sb[15:8] != ~sb[7:0])
                        begin
                            sc             = 6'd0;
                            receiving_next = 1'b0;
                        end
                        sb = 16'd0;
                    end
                    SYM_CMD_DONE:
                    begin
                        hk = sb[7:0];
                        sb = 16'd0;
                    end
                    SYM_CHK_DONE:
                    begin
                        if (hk != ~sb[7:0])
                        begin
                            hk = 8'd0;
                        end
                        sb                      = 16'd0;
                        sc                      = SYM_FINISHED;
                        result.valid            = 1'b1;
                        result.word.key_code    = hk;
                        result.word.is_repeat   = 1'b0;
                    end
                    SYM_REPEAT:
                    begin
                        sc                      = SYM_FINISHED;
                        result.valid            = 1'b1;
                        result.word.key_code    = hk;
                        result.word.is_repeat   = 1'b1;
                    end
                    default:
                    begin
                        sc = sc;
                    end
                endcase
                shift_bits_next   = sb;
                symbol_count_next = sc;
                held_key_next     = hk;
            end
        end
    end

    // control state
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            pair_started_reg <= 1'b0;
            receiving_reg    <= 1'b0;
            idle_ticks_reg   <= 8'd0;
            shift_bits_reg   <= 16'd0;
            symbol_count_reg <= 6'd0;
            repeat_seen_reg  <= 8'd0;
            held_key_reg     <= 8'd0;
        end
        else
        begin
            pair_started_reg <= pair_started_next;
            receiving_reg    <= receiving_next;
            idle_ticks_reg   <= idle_ticks_next;
            shift_bits_reg   <= shift_bits_next;
            symbol_count_reg <= symbol_count_next;
            repeat_seen_reg  <= repeat_seen_next;
            held_key_reg     <= held_key_next;
        end
    end

endmodule

// ===== rtl/nirp_out_buf.sv =====
// nirp_out_buf: output register with one skid slot
// holds results while the receiver stalls; stalls intake when the skid is full
// depends on nirp_pkg
module nirp_out_buf
    import nirp_pkg::*;
(
    input  logic      clk,
    input  logic      rst_n,
    input  result_t   result,
    output logic      full,
    output logic      key_valid,
    input  logic      key_stall,
    output key_word_t key_word
);

    logic      out_valid_reg, out_valid_next;
    logic      skid_valid_reg, skid_valid_next;
    key_word_t out_word_reg, out_word_next;
    key_word_t skid_word_reg, skid_word_next;
    logic      slot_free;

    assign slot_free = !out_valid_reg || !key_stall;

    // slot steering
    always_comb
    begin
        out_valid_next  = out_valid_reg;
        skid_valid_next = skid_valid_reg;
        out_word_next   = out_word_reg;
        skid_word_next  = skid_word_reg;
        if (slot_free)
        begin
            priority if (skid_valid_reg)
            begin
                out_valid_next  = 1'b1;
                out_word_next   = skid_word_reg;
                skid_valid_next = 1'b0;
            end
            else if (result.valid)
            begin
                out_valid_next = 1'b1;
                out_word_next  = result.word;
            end
            else
            begin
                out_valid_next = 1'b0;
            end
        end
        else if (result.valid)
        begin
            skid_valid_next = 1'b1;
            skid_word_next  = result.word;
        end
    end

    // valid flags
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            out_valid_reg  <= 1'b0;
            skid_valid_reg <= 1'b0;
        end
        else
        begin
            out_valid_reg  <= out_valid_next;
            skid_valid_reg <= skid_valid_next;
        end
    end

    // payload
    always_ff @(posedge clk)
    begin
        out_word_reg  <= out_word_next;
        skid_word_reg <= skid_word_next;
    end

    assign full      = skid_valid_reg;
    assign key_valid = out_valid_reg;
    assign key_word  = out_word_reg;

endmodule

// ===== rtl/nec_ir_pulse_decoder.sv =====
// nec_ir_pulse_decoder: top level of the nec ir frame decoder
// holds configuration registers and joins decoder core and output buffer
// depends on nirp_pkg, nirp_core, nirp_out_buf
//
// usage:
// ir channel (ir_valid, ir_stall, ir_word) carries timer ticks (mode 0) and
// edge events (mode 1) with the pulse width in microseconds. a word is taken
// at a clock edge with ir_valid high and ir_stall low.
// key channel (key_valid, key_stall, key_word) delivers decoded keys; a word
// leaves at a clock edge with key_valid high and key_stall low.
// each ir word is decoded in the cycle it is taken; a key it causes is
// registered in the output register, or in the skid slot while the receiver
// stalls. one ir word per cycle is accepted while ir_stall is low.
// when the receiver stalls, one key waits in the output register and one in
// a skid slot; ir_stall rises only while the skid slot holds a key.
// cfg_we/cfg_index/cfg_data write one of the three 8-bit settings, chosen by
// cfg_index; indexes past the list are ignored.
// reset clears all decoder state and the buffer, and restores the settings
// to skip 3, frame timeout 3 and repeat timeout 9 ticks.
module nec_ir_pulse_decoder
    import nirp_pkg::*;
(
    input  logic                   clk,
    input  logic                   rst_n,
    input  logic                   ir_valid,
    output logic                   ir_stall,
    input  ir_word_t               ir_word,
    output logic                   key_valid,
    input  logic                   key_stall,
    output key_word_t              key_word,
    input  logic                   cfg_we,
    input  logic [CFG_INDEX_W-1:0] cfg_index,
    input  logic [7:0]             cfg_data
);

    cfg_t    cfg_reg, cfg_next;
    result_t result;
    logic    ir_fire;

    assign ir_fire = ir_valid && !ir_stall;

    // configuration writes
    always_comb
    begin
        cfg_next = cfg_reg;
        if (cfg_we)
        begin
            case (cfg_index)
                CFG_REPEAT_SKIP:    cfg_next.repeat_skip_count    = cfg_data;
                CFG_FRAME_TIMEOUT:  cfg_next.frame_timeout_ticks  = cfg_data;
                CFG_REPEAT_TIMEOUT: cfg_next.repeat_timeout_ticks = cfg_data;
                default:            cfg_next = cfg_reg;
            endcase
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            cfg_reg.repeat_skip_count    <= RST_REPEAT_SKIP;
            cfg_reg.frame_timeout_ticks  <= RST_FRAME_TIMEOUT;
            cfg_reg.repeat_timeout_ticks <= RST_REPEAT_TIMEOUT;
        end
        else
        begin
            cfg_reg <= cfg_next;
        end
    end

    // decoder core
    nirp_core u_core (
        .clk    (clk),
        .rst_n  (rst_n),
        .fire   (ir_fire),
        .word   (ir_word),
        .cfg    (cfg_reg),
        .result (result)
    );

    // output buffer
    nirp_out_buf u_out_buf (
        .clk       (clk),
        .rst_n     (rst_n),
        .result    (result),
        .full      (ir_stall),
        .key_valid (key_valid),
        .key_stall (key_stall),
        .key_word  (key_word)
    );

`ifndef SYNTHESIS
    // intake stalls only while a key is waiting
    a_stall_needs_key: assert property (@(posedge clk) disable iff (!rst_n)
        ir_stall |-> key_valid)
        else $error("ir_stall without a pending key");

    // a produced key leaves key_valid high next cycle
    a_key_follows: assert property (@(posedge clk) disable iff (!rst_n)
        (ir_fire && result.valid) |=> key_valid)
        else $error("decoded key not presented");

    // a taken key with nothing behind it empties the output
    a_drain: assert property (@(posedge clk) disable iff (!rst_n)
        (key_valid && !key_stall && !ir_stall && !(ir_fire && result.valid))
        |=> !key_valid)
        else $error("key shown twice");
`endif

endmodule
